[design/timer_table_with_groups_assert.svh]
// Assertion macros for the timer table block.
`ifndef TIMER_TABLE_WITH_GROUPS_ASSERT_SVH
`define TIMER_TABLE_WITH_GROUPS_ASSERT_SVH

// Condition that holds at every clock edge out of reset.
`define TTG_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define TTG_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/ttg_pkg.sv]
// Shared constants and codes for the timer table block.
package ttg_pkg;

  localparam int FUNC_W = 4;
  localparam int TID_W  = 5;
  localparam int GID_W  = 4;
  localparam int TIME_W = 32;
  localparam int KIND_W = 2;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 5;
  localparam int MASK_W = 16;
  localparam int MAX_RES = 16;

  localparam logic [FUNC_W-1:0] FN_TICK      = 4'd0;
  localparam logic [FUNC_W-1:0] FN_CREATE    = 4'd1;
  localparam logic [FUNC_W-1:0] FN_CANCEL    = 4'd2;
  localparam logic [FUNC_W-1:0] FN_MODIFY    = 4'd3;
  localparam logic [FUNC_W-1:0] FN_EXISTS    = 4'd4;
  localparam logic [FUNC_W-1:0] FN_COUNT     = 4'd5;
  localparam logic [FUNC_W-1:0] FN_CLEAR     = 4'd6;
  localparam logic [FUNC_W-1:0] FN_NEWGROUP  = 4'd7;
  localparam logic [FUNC_W-1:0] FN_ADDGRP    = 4'd8;
  localparam logic [FUNC_W-1:0] FN_RMGRP     = 4'd9;
  localparam logic [FUNC_W-1:0] FN_CANCELGRP = 4'd10;
  localparam logic [FUNC_W-1:0] FN_LISTGRP   = 4'd11;

  localparam logic [KIND_W-1:0] K_REPLY     = 2'd0;
  localparam logic [KIND_W-1:0] K_EXPIRY    = 2'd1;
  localparam logic [KIND_W-1:0] K_IDLE_TICK = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_FAIL = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

endpackage

[design/ttg_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ttg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/timer_table_with_groups.sv]
// Timer table with groups: request decoder, flag tables and tick scan sequencer.
//
//   channel  signals                                              dir
//   input    in_valid in_stall func timer_num group_num delay      in
//            period repeat_mode
//   output   out_valid out_stall kind status result_timer          out
//            result_group live_count member_mask last
//
// A request other than tick is decoded in the cycle it transfers; its reply is
// registered and valid the next cycle, and a new request is taken whenever
// out_stall does not hold the previous reply. A tick scans the timer RAM slot by
// slot, each in S_RD (read) and then S_CHK (check and write back), then flushes
// the final result in S_FLUSH; a result held by out_stall holds S_CHK or S_FLUSH.
// Reset clears time, live flags, group membership and group flags; the timer
// RAM is not cleared, since an entry's data is only used once its slot is live.
`include "timer_table_with_groups_assert.svh"

module timer_table_with_groups import ttg_pkg::*; #(
  parameter int NUM_TIMERS = 16,
  parameter int NUM_GROUPS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [FUNC_W-1:0] func,
  input  logic [TID_W-1:0]  timer_num,
  input  logic [GID_W-1:0]  group_num,
  input  logic [TIME_W-1:0] delay,
  input  logic [TIME_W-1:0] period,
  input  logic              repeat_mode,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [KIND_W-1:0] kind,
  output logic [STAT_W-1:0] status,
  output logic [TID_W-1:0]  result_timer,
  output logic [GID_W-1:0]  result_group,
  output logic [CNT_W-1:0]  live_count,
  output logic [MASK_W-1:0] member_mask,
  output logic              last
);

  localparam int TW = $clog2(NUM_TIMERS);
  localparam int GW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int EW = 1 + 2 * TIME_W;
  localparam int MASK_N = (NUM_TIMERS < MASK_W) ? NUM_TIMERS : MASK_W;

  typedef enum logic [1:0] {S_IDLE, S_RD, S_CHK, S_FLUSH} state_t;

  state_t             state;
  logic [TIME_W-1:0]  now_ms;
  logic [NUM_TIMERS-1:0] slot_live;
  logic [GID_W-1:0]   member_of [NUM_TIMERS];
  logic [NUM_GROUPS-1:0] group_live;
  logic [TW-1:0]      scan_idx;
  logic [CNT_W-1:0]   nfound;
  logic               pend;
  logic [TW-1:0]      pend_slot;

  // RAM entry: {periodic, period, due}
  logic               ram_we;
  logic [TW-1:0]      ram_waddr;
  logic [EW-1:0]      ram_wdata;
  logic [EW-1:0]      ram_rdata;
  logic               rd_periodic;
  logic [TIME_W-1:0]  rd_period;
  logic [TIME_W-1:0]  rd_due;
  logic [TIME_W-1:0]  due_diff;

  logic               accept;
  logic               o_free;
  logic [TW-1:0]      tid_idx;
  logic               timer_ok;
  logic [GW-1:0]      gid_idx;
  logic               group_ok;
  logic               free_found;
  logic [TW-1:0]      free_idx;
  logic               gfree_found;
  logic [GW-1:0]      gfree_idx;
  logic [MASK_W-1:0]  list_mask;
  logic [TW-1:0]      leave_slot;
  logic [GID_W-1:0]   leave_grp;
  logic               leave_others;
  logic               leave_erase;
  logic [GW-1:0]      leave_gidx;
  logic               due_hit;
  logic               chk_go;
  logic               scan_done;
  logic [STAT_W-1:0]  rep_status;
  logic [TID_W-1:0]   rep_timer;
  logic [GID_W-1:0]   rep_group;
  logic [CNT_W-1:0]   rep_count;
  logic [MASK_W-1:0]  rep_mask;
  logic [NUM_TIMERS-1:0] orphan;

  assign o_free   = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE) || !o_free;
  assign accept   = in_valid && !in_stall;

  assign tid_idx  = TW'(timer_num - TID_W'(1));
  assign timer_ok = (timer_num != '0) && (int'(timer_num) <= NUM_TIMERS) && slot_live[tid_idx];
  assign gid_idx  = GW'(group_num - GID_W'(1));
  assign group_ok = (group_num != '0) && (int'(group_num) <= NUM_GROUPS) && group_live[gid_idx];

  assign {rd_periodic, rd_period, rd_due} = ram_rdata;
  assign due_diff  = now_ms - rd_due;
  assign due_hit   = slot_live[scan_idx] && !due_diff[TIME_W-1];
  assign chk_go    = !(due_hit && pend && !o_free);
  assign scan_done = (scan_idx == TW'(NUM_TIMERS - 1)) ||
                     (due_hit && nfound == CNT_W'(MAX_RES - 1));

  // lowest free timer slot and group slot
  always_comb begin
    free_found  = 1'b0;
    free_idx    = '0;
    for (int s = NUM_TIMERS - 1; s >= 0; s--) begin
      if (!slot_live[s]) begin
        free_found = 1'b1;
        free_idx   = TW'(s);
      end
    end
    gfree_found = 1'b0;
    gfree_idx   = '0;
    for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
      if (!group_live[g]) begin
        gfree_found = 1'b1;
        gfree_idx   = GW'(g);
      end
    end
  end

  always_comb begin
    list_mask = '0;
    for (int s = 0; s < MASK_N; s++) begin
      list_mask[s] = slot_live[s] && (member_of[s] == group_num);
    end
  end

  always_comb begin
    for (int s = 0; s < NUM_TIMERS; s++) begin
      orphan[s] = (member_of[s] != '0) && !slot_live[s];
    end
  end

  // a slot leaving its group: erase the group when no other live member is left
  assign leave_slot = (state == S_CHK) ? scan_idx : tid_idx;
  assign leave_grp  = member_of[leave_slot];
  assign leave_gidx = GW'(leave_grp - GID_W'(1));
  always_comb begin
    leave_others = 1'b0;
    for (int s = 0; s < NUM_TIMERS; s++) begin
      if (TW'(s) != leave_slot && slot_live[s] && member_of[s] == leave_grp) begin
        leave_others = 1'b1;
      end
    end
  end
  assign leave_erase = (leave_grp != '0) && (int'(leave_grp) <= NUM_GROUPS) && !leave_others;

  always_comb begin
    rep_status = ST_OK;
    rep_timer  = '0;
    rep_group  = '0;
    rep_count  = '0;
    rep_mask   = '0;
    case (func)
      FN_CREATE: begin
        if (free_found) begin
          rep_timer = TID_W'(int'(free_idx) + 1);
        end else begin
          rep_status = ST_FULL;
        end
      end
      FN_CANCEL, FN_MODIFY, FN_EXISTS: begin
        rep_status = timer_ok ? ST_OK : ST_FAIL;
      end
      FN_COUNT: begin
        rep_count = CNT_W'($countones(slot_live));
      end
      FN_CLEAR: begin
        rep_status = ST_OK;
      end
      FN_NEWGROUP: begin
        if (gfree_found) begin
          rep_group = GID_W'(int'(gfree_idx) + 1);
        end else begin
          rep_status = ST_FULL;
        end
      end
      FN_ADDGRP: begin
        rep_status = (timer_ok && group_ok) ? ST_OK : ST_FAIL;
      end
      FN_RMGRP: begin
        rep_status = (group_num != '0 && timer_ok && member_of[tid_idx] == group_num) ?
                     ST_OK : ST_FAIL;
      end
      FN_CANCELGRP: begin
        rep_status = group_ok ? ST_OK : ST_FAIL;
      end
      FN_LISTGRP: begin
        rep_status = group_ok ? ST_OK : ST_FAIL;
        rep_mask   = group_ok ? list_mask : '0;
      end
      default: begin
        rep_status = ST_FAIL;
      end
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = tid_idx;
    ram_wdata = {repeat_mode, period, now_ms + delay};
    if (state == S_CHK) begin
      ram_we    = chk_go && due_hit && rd_periodic;
      ram_waddr = scan_idx;
      ram_wdata = {1'b1, rd_period, now_ms + rd_period};
    end else if (accept) begin
      if (func == FN_CREATE) begin
        ram_we    = free_found;
        ram_waddr = free_idx;
      end else if (func == FN_MODIFY) begin
        ram_we    = timer_ok;
      end
    end
  end

  ttg_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_TIMERS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (state == S_RD),
    .raddr (scan_idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      now_ms     <= '0;
      slot_live  <= '0;
      group_live <= '0;
      pend       <= 1'b0;
      nfound     <= '0;
      scan_idx   <= '0;
      for (int s = 0; s < NUM_TIMERS; s++) begin
        member_of[s] <= '0;
      end
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (func == FN_TICK) begin
              now_ms   <= now_ms + TIME_W'(1);
              scan_idx <= '0;
              nfound   <= '0;
              pend     <= 1'b0;
              state    <= S_RD;
            end else begin
              out_valid    <= 1'b1;
              kind         <= K_REPLY;
              status       <= rep_status;
              result_timer <= rep_timer;
              result_group <= rep_group;
              live_count   <= rep_count;
              member_mask  <= rep_mask;
              last         <= 1'b1;
              case (func)
                FN_CREATE: begin
                  if (free_found) begin
                    slot_live[free_idx] <= 1'b1;
                    member_of[free_idx] <= '0;
                  end
                end
                FN_CANCEL: begin
                  if (timer_ok) begin
                    slot_live[tid_idx] <= 1'b0;
                    member_of[tid_idx] <= '0;
                    if (leave_erase) begin
                      group_live[leave_gidx] <= 1'b0;
                    end
                  end
                end
                FN_CLEAR: begin
                  slot_live  <= '0;
                  group_live <= '0;
                  for (int s = 0; s < NUM_TIMERS; s++) begin
                    member_of[s] <= '0;
                  end
                end
                FN_NEWGROUP: begin
                  if (gfree_found) begin
                    group_live[gfree_idx] <= 1'b1;
                  end
                end
                FN_ADDGRP: begin
                  if (timer_ok && group_ok && member_of[tid_idx] != group_num) begin
                    member_of[tid_idx] <= group_num;
                    if (leave_erase) begin
                      group_live[leave_gidx] <= 1'b0;
                    end
                  end
                end
                FN_RMGRP: begin
                  if (rep_status == ST_OK) begin
                    member_of[tid_idx] <= '0;
                    if (leave_erase) begin
                      group_live[leave_gidx] <= 1'b0;
                    end
                  end
                end
                FN_CANCELGRP: begin
                  if (group_ok) begin
                    for (int s = 0; s < NUM_TIMERS; s++) begin
                      if (slot_live[s] && member_of[s] == group_num) begin
                        slot_live[s] <= 1'b0;
                        member_of[s] <= '0;
                      end
                    end
                    group_live[gid_idx] <= 1'b0;
                  end
                end
                default: begin
                end
              endcase
            end
          end
        end
        S_RD: begin
          state <= S_CHK;
        end
        S_CHK: begin
          if (chk_go) begin
            if (due_hit) begin
              // previous expiry is known not to be the last one
              if (pend) begin
                out_valid    <= 1'b1;
                kind         <= K_EXPIRY;
                status       <= ST_OK;
                result_timer <= TID_W'(int'(pend_slot) + 1);
                result_group <= '0;
                live_count   <= '0;
                member_mask  <= '0;
                last         <= 1'b0;
              end
              pend      <= 1'b1;
              pend_slot <= scan_idx;
              nfound    <= nfound + CNT_W'(1);
              if (!rd_periodic) begin
                slot_live[scan_idx] <= 1'b0;
                member_of[scan_idx] <= '0;
                if (leave_erase) begin
                  group_live[leave_gidx] <= 1'b0;
                end
              end
            end
            if (scan_done) begin
              state <= S_FLUSH;
            end else begin
              scan_idx <= scan_idx + TW'(1);
              state    <= S_RD;
            end
          end
        end
        S_FLUSH: begin
          if (o_free) begin
            out_valid    <= 1'b1;
            kind         <= pend ? K_EXPIRY : K_IDLE_TICK;
            status       <= ST_OK;
            result_timer <= pend ? TID_W'(int'(pend_slot) + 1) : '0;
            result_group <= '0;
            live_count   <= '0;
            member_mask  <= '0;
            last         <= 1'b1;
            pend         <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `TTG_CHECK(a_no_orphan_member, orphan == '0, "group member on a free slot")
  `TTG_CHECK(a_result_cap, nfound <= CNT_W'(MAX_RES), "too many expiries in one tick")
  `TTG_NEXT(a_tick_starts_scan, accept && func == FN_TICK, state == S_RD && scan_idx == '0,
            "tick did not start the scan")
  `TTG_NEXT(a_reply_loaded, accept && func != FN_TICK, out_valid && last && kind == K_REPLY,
            "request reply not loaded")

endmodule

[verif/tb_timer_table_with_groups.sv]
// Testbench for the timer table with groups: directed and random requests checked against a local model.
`timescale 1ns / 1ps

class timer_scoreboard;
  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [4:0]  tmr;
    logic [3:0]  grp;
    logic [4:0]  cnt;
    logic [15:0] mask;
    logic        last;
  } reply_t;

  bit [31:0] now_ms;
  bit        live [16];
  bit [31:0] due [16];
  bit [31:0] per [16];
  bit        rep [16];
  bit [3:0]  member [16];
  bit        glive [8];
  reply_t    pending [$];
  int        errors;

  function void clear_all();
    for (int s = 0; s < 16; s++) begin
      live[s] = 0;
      member[s] = 0;
    end
    for (int g = 0; g < 8; g++) glive[g] = 0;
  endfunction

  function bit timer_ok(bit [4:0] id);
    return id >= 1 && id <= 16 && live[id - 1];
  endfunction

  function bit group_ok(bit [3:0] id);
    return id >= 1 && id <= 8 && glive[id - 1];
  endfunction

  function void leave_group(int s);
    bit [3:0] g;
    bit used;
    g = member[s];
    member[s] = 0;
    used = 0;
    if (g >= 1 && g <= 8) begin
      for (int t = 0; t < 16; t++) if (live[t] && member[t] == g) used = 1;
      if (!used) glive[g - 1] = 0;
    end
  endfunction

  function void push(bit [1:0] k, bit [1:0] st, bit [4:0] t, bit [3:0] g,
                     bit [4:0] c, bit [15:0] m);
    reply_t r;
    r = '{k, st, t, g, c, m, 1'b0};
    pending = {pending, r};
  endfunction

  // Work out the results of one accepted request.
  function void note_request(bit [3:0] fn, bit [4:0] tid, bit [3:0] gid,
                             bit [31:0] dly, bit [31:0] prd, bit rm);
    int n;
    int s;
    bit ok;
    bit [4:0] c;
    bit [15:0] m;
    n = 0;
    ok = 0;
    c = 0;
    m = 0;
    case (fn)
      ttg_pkg::FN_TICK: begin
        now_ms++;
        for (s = 0; s < 16 && n < 16; s++) begin
          if (!live[s] || (now_ms - due[s]) >= 32'h8000_0000) continue;
          push(ttg_pkg::K_EXPIRY, ttg_pkg::ST_OK, s + 1, 0, 0, 0);
          n++;
          if (rep[s]) due[s] = now_ms + per[s];
          else begin
            leave_group(s);
            live[s] = 0;
          end
        end
        if (n == 0) push(ttg_pkg::K_IDLE_TICK, ttg_pkg::ST_OK, 0, 0, 0, 0);
      end
      ttg_pkg::FN_CREATE: begin
        for (s = 0; s < 16 && live[s]; s++) ;
        if (s >= 16) push(ttg_pkg::K_REPLY, ttg_pkg::ST_FULL, 0, 0, 0, 0);
        else begin
          live[s] = 1;
          due[s] = now_ms + dly;
          per[s] = prd;
          rep[s] = rm;
          member[s] = 0;
          push(ttg_pkg::K_REPLY, ttg_pkg::ST_OK, s + 1, 0, 0, 0);
        end
      end
      ttg_pkg::FN_CANCEL: begin
        ok = timer_ok(tid);
        if (ok) begin
          leave_group(tid - 1);
          live[tid - 1] = 0;
        end
      end
      ttg_pkg::FN_MODIFY: begin
        ok = timer_ok(tid);
        if (ok) begin
          due[tid - 1] = now_ms + dly;
          per[tid - 1] = prd;
          rep[tid - 1] = rm;
        end
      end
      ttg_pkg::FN_EXISTS: ok = timer_ok(tid);
      ttg_pkg::FN_COUNT: begin
        ok = 1;
        for (s = 0; s < 16; s++) c += live[s];
      end
      ttg_pkg::FN_CLEAR: begin
        ok = 1;
        clear_all();
      end
      ttg_pkg::FN_NEWGROUP: begin
        for (s = 0; s < 8 && glive[s]; s++) ;
        if (s >= 8) push(ttg_pkg::K_REPLY, ttg_pkg::ST_FULL, 0, 0, 0, 0);
        else begin
          glive[s] = 1;
          push(ttg_pkg::K_REPLY, ttg_pkg::ST_OK, 0, s + 1, 0, 0);
        end
      end
      ttg_pkg::FN_ADDGRP: begin
        ok = timer_ok(tid) && group_ok(gid);
        if (ok && member[tid - 1] != gid) begin
          leave_group(tid - 1);
          member[tid - 1] = gid;
        end
      end
      ttg_pkg::FN_RMGRP: begin
        ok = gid != 0 && timer_ok(tid) && member[tid - 1] == gid;
        if (ok) leave_group(tid - 1);
      end
      ttg_pkg::FN_CANCELGRP: begin
        ok = group_ok(gid);
        if (ok) begin
          for (s = 0; s < 16; s++)
            if (live[s] && member[s] == gid) begin
              live[s] = 0;
              member[s] = 0;
            end
          glive[gid - 1] = 0;
        end
      end
      ttg_pkg::FN_LISTGRP: begin
        ok = group_ok(gid);
        if (ok)
          for (s = 0; s < 16; s++) if (live[s] && member[s] == gid) m[s] = 1;
      end
      default: ok = 0;
    endcase
    if (fn != ttg_pkg::FN_TICK && fn != ttg_pkg::FN_CREATE && fn != ttg_pkg::FN_NEWGROUP)
      push(ttg_pkg::K_REPLY, ok ? ttg_pkg::ST_OK : ttg_pkg::ST_FAIL, 0, 0, c, m);
    pending[$].last = 1;
  endfunction

  task report(string what, int got, int want);
    errors++;
    $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $time);
  endtask

  task check_result(reply_t got);
    reply_t w;
    if (pending.size() == 0) begin
      report("unexpected result", 1, 0);
      return;
    end
    w = pending.pop_front();
    if (got.kind !== w.kind) report("kind", got.kind, w.kind);
    if (got.status !== w.status) report("status", got.status, w.status);
    if (got.tmr !== w.tmr) report("result_timer", got.tmr, w.tmr);
    if (got.grp !== w.grp) report("result_group", got.grp, w.grp);
    if (got.cnt !== w.cnt) report("live_count", got.cnt, w.cnt);
    if (got.mask !== w.mask) report("member_mask", got.mask, w.mask);
    if (got.last !== w.last) report("last", got.last, w.last);
  endtask
endclass

module tb_timer_table_with_groups;
  import ttg_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [FUNC_W-1:0] func = 0;
  logic [TID_W-1:0] timer_num = 0;
  logic [GID_W-1:0] group_num = 0;
  logic [TIME_W-1:0] delay = 0;
  logic [TIME_W-1:0] period = 0;
  logic repeat_mode = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [KIND_W-1:0] kind;
  logic [STAT_W-1:0] status;
  logic [TID_W-1:0] result_timer;
  logic [GID_W-1:0] result_group;
  logic [CNT_W-1:0] live_count;
  logic [MASK_W-1:0] member_mask;
  logic last;

  timer_scoreboard sb = new();
  bit sending_done = 0;
  bit hold_off = 0;
  int idle_cycles = 0;
  int out_gap = 0;

  timer_table_with_groups u_dut (.*);

  always #5 clk = ~clk;

  function automatic int gap_len();
    return ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(5, 30);
  endfunction

  // Valid stays high between back-to-back transfers; it drops only for a gap.
  task automatic send_request(bit [3:0] fn, bit [4:0] tid, bit [3:0] gid,
                              bit [31:0] dly, bit [31:0] prd, bit rm);
    int g;
    g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1;
    func <= fn;
    timer_num <= tid;
    group_num <= gid;
    delay <= dly;
    period <= prd;
    repeat_mode <= rm;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(fn, tid, gid, dly, prd, rm);
    @(negedge clk);
  endtask

  // Small delays near now so timers actually fire; sometimes wide values.
  function automatic bit [31:0] pick_time();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000 - $urandom_range(0, 2);
      default: return $urandom_range(0, 6);
    endcase
  endfunction

  task automatic random_request();
    bit [3:0] fn;
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) fn = FN_TICK;
    else if (r < 55) fn = FN_CREATE;
    else if (r < 97) fn = $urandom_range(2, 11);
    else fn = $urandom_range(12, 15);
    send_request(fn, ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(1, 16),
                 ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(1, 8),
                 pick_time(), pick_time(), $urandom());
  endtask

  // Output side: stall runs of random length plus one long hold-off.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 0;
    end else if (hold_off) begin
      out_stall <= 1;
    end else if (out_gap > 0) begin
      out_stall <= 1;
      out_gap = out_gap - 1;
    end else begin
      out_stall <= 0;
      if ($urandom_range(0, 99) < 20) out_gap = gap_len();
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result('{kind, status, result_timer, result_group, live_count,
                        member_mask, last});
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 4000) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed part
    send_request(FN_TICK, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
    send_request(FN_CREATE, 0, 0, 0, 0, 1);
    send_request(FN_CREATE, 0, 0, 1, 0, 0);
    send_request(FN_CREATE, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_request(FN_NEWGROUP, 0, 0, 0, 0, 0);
    send_request(FN_NEWGROUP, 0, 0, 0, 0, 0);
    send_request(FN_ADDGRP, 1, 1, 0, 0, 0);
    send_request(FN_ADDGRP, 1, 1, 0, 0, 0);
    send_request(FN_ADDGRP, 2, 1, 0, 0, 0);
    send_request(FN_LISTGRP, 0, 1, 0, 0, 0);
    send_request(FN_ADDGRP, 1, 2, 0, 0, 0);
    send_request(FN_RMGRP, 2, 0, 0, 0, 0);
    send_request(FN_RMGRP, 2, 1, 0, 0, 0);
    send_request(FN_LISTGRP, 0, 15, 0, 0, 0);
    send_request(FN_TICK, 0, 0, 0, 0, 0);
    send_request(FN_EXISTS, 31, 0, 0, 0, 0);
    send_request(FN_MODIFY, 3, 0, 2, 3, 1);
    send_request(FN_COUNT, 0, 0, 0, 0, 0);
    send_request(FN_CANCELGRP, 0, 2, 0, 0, 0);
    send_request(FN_CANCEL, 3, 0, 0, 0, 0);
    send_request(4'd15, 0, 0, 0, 0, 0);
    send_request(FN_CLEAR, 0, 0, 0, 0, 0);
    // fill the table, overflow, all due on one tick under a long hold-off
    for (int i = 0; i < 17; i++) send_request(FN_CREATE, 0, 0, 1, 0, i[0]);
    for (int i = 0; i < 9; i++) send_request(FN_NEWGROUP, 0, 0, 0, 0, 0);
    hold_off = 1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      begin
        for (int i = 0; i < 4; i++) send_request(FN_TICK, 0, 0, 0, 0, 0);
        in_valid <= 0;
      end
    join
    @(negedge clk);
    send_request(FN_CLEAR, 0, 0, 0, 0, 0);
    for (int i = 0; i < 210; i++) random_request();
    in_valid <= 0;
    sending_done = 1;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
